// ----- hw/rtl/k_decreasing_subsequence_counter_top_macros.svh -----
// Assertion macros for the checker file of the subsequence counter.
`ifndef K_DECREASING_SUBSEQUENCE_COUNTER_TOP_MACROS_SVH
`define K_DECREASING_SUBSEQUENCE_COUNTER_TOP_MACROS_SVH

// Checked outside reset only.
`define KDSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define KDSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hw/rtl/kdsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdsc_pkg
// Shared constants, the cell control word and modular arithmetic for the
// decreasing subsequence counter.
// ----------------------------------------------------------------------------
package kdsc_pkg;

  localparam int unsigned DEF_VALUE_DOMAIN = 1024;
  localparam int unsigned DEF_MAX_LEVELS   = 8;
  localparam int unsigned CNT_W            = 30;
  localparam int unsigned VAL_W            = 11;
  localparam int unsigned LEN_W            = 4;
  localparam logic [LEN_W-1:0] LEN_RESET   = 4'd2;
  localparam logic [CNT_W-1:0] COUNT_MOD   = 30'd1000000000;

  // Control word the sequencer sends to every cell.
  typedef struct packed {
    logic clr;   // clear the query accumulator
    logic rd;    // read one tree node
    logic acc;   // add the read node into the accumulator
    logic wr;    // write the node back with the neighbor's count added
    logic wipe;  // write zero during the clearing pass
  } ctl_t;

  // Sum of two residues, reduced once.
  function automatic logic [CNT_W-1:0] add_mod(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, COUNT_MOD}) begin
      s = s - {1'b0, COUNT_MOD};
    end
    return s[CNT_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/k_decreasing_subsequence_counter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_decreasing_subsequence_counter_top
// Counts strictly decreasing subsequences of length k, modulo 1e9, over a
// stream of values; one chained cell per level 2..MAX_LEVELS.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (value_i, last_i) are taken on in_valid_i while in_stall_o is
//   low; each word yields one result word (count_o, final_res_o) on
//   out_valid_o, held while out_stall_i is high.
//   subsequence_length_i is written on subsequence_length_we_i; the user must
//   do so only while idle, the block itself does not enforce it. Per word
//   the cells walk the Fenwick trees in lockstep: a query pass (read,
//   accumulate) and then an update pass (read, write). For a power-of-two
//   VALUE_DOMAIN the two passes together always visit log2(VALUE_DOMAIN)+1
//   nodes; each node is read and then accumulated or written back, as the
//   tree memory read is registered. One word is processed at a time; the
//   next can be taken while the previous result still waits in the output
//   register. After reset and after each word marked last, a clearing pass
//   zeroes all trees; no word is taken meanwhile. A stalled receiver holds
//   the finished result and delays the next one.
// ----------------------------------------------------------------------------
module k_decreasing_subsequence_counter_top #(
  parameter int unsigned VALUE_DOMAIN = kdsc_pkg::DEF_VALUE_DOMAIN,
  parameter int unsigned MAX_LEVELS   = kdsc_pkg::DEF_MAX_LEVELS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        subsequence_length_we_i,
  input  logic [kdsc_pkg::LEN_W-1:0]  subsequence_length_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [kdsc_pkg::VAL_W-1:0]  value_i,
  input  logic                        last_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [kdsc_pkg::CNT_W-1:0]  count_o,
  output logic                        final_res_o
);

  localparam int unsigned AW = $clog2(VALUE_DOMAIN);
  localparam int unsigned IW = $clog2(VALUE_DOMAIN + 1);
  localparam int unsigned NC = MAX_LEVELS - 1;
  localparam int unsigned LW = $clog2(MAX_LEVELS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_QRD   = 3'd2;
  localparam logic [2:0] S_QACC  = 3'd3;
  localparam logic [2:0] S_URD   = 3'd4;
  localparam logic [2:0] S_UWR   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]                 state_q, state_d;
  logic [IW-1:0]              i_q, i_d;
  logic [IW-1:0]              pos_q, pos_d;
  logic                       last_q, last_d;
  logic [kdsc_pkg::LEN_W-1:0] k_q;
  logic [kdsc_pkg::CNT_W-1:0] total_q, total_d;
  logic                       out_valid_q;
  logic [kdsc_pkg::CNT_W-1:0] count_q;
  logic                       final_q;

  kdsc_pkg::ctl_t             ctl;
  logic [AW-1:0]              addr;
  logic [IW-1:0]              im1, lowbit, qnext;
  logic [IW:0]                unext;
  logic [31:0]                v_ext, v_cl, k_ext, k_cl;
  logic [IW-1:0]              q_start, u_start;
  logic [LW-1:0]              kidx;
  logic                       accept, out_ld;
  logic [kdsc_pkg::CNT_W-1:0] ends [MAX_LEVELS];

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  // Clamp the value and map it to a reversed tree position.
  assign v_ext   = 32'(value_i);
  assign v_cl    = (v_ext == 32'd0) ? 32'd1 :
                   ((v_ext > VALUE_DOMAIN) ? 32'(VALUE_DOMAIN) : v_ext);
  assign q_start = IW'(VALUE_DOMAIN - v_cl);
  assign u_start = IW'(VALUE_DOMAIN - v_cl + 32'd1);

  // Clamp the configured length and select the matching level.
  assign k_ext = 32'(k_q);
  assign k_cl  = (k_ext == 32'd0) ? 32'd1 :
                 ((k_ext > MAX_LEVELS) ? 32'(MAX_LEVELS) : k_ext);
  assign kidx  = LW'(k_cl - 32'd1);

  // Fenwick index arithmetic.
  assign im1    = i_q - IW'(1);
  assign lowbit = i_q & (~i_q + IW'(1));
  assign qnext  = i_q - lowbit;
  assign unext  = {1'b0, i_q} + {1'b0, lowbit};

  assign out_ld = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  // Sequencer driving all cells in lockstep.
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    pos_d   = pos_q;
    last_d  = last_q;
    ctl     = '0;
    addr    = im1[AW-1:0];
    unique case (state_q)
      S_CLEAR: begin
        ctl.wipe = 1'b1;
        addr     = i_q[AW-1:0];
        if (i_q == IW'(VALUE_DOMAIN - 1)) begin
          i_d     = '0;
          state_d = S_IDLE;
        end else begin
          i_d = i_q + IW'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          ctl.clr = 1'b1;
          pos_d   = u_start;
          last_d  = last_i;
          if (q_start == '0) begin
            i_d     = u_start;
            state_d = S_URD;
          end else begin
            i_d     = q_start;
            state_d = S_QRD;
          end
        end
      end
      S_QRD: begin
        ctl.rd  = 1'b1;
        state_d = S_QACC;
      end
      S_QACC: begin
        ctl.acc = 1'b1;
        if (qnext == '0) begin
          i_d     = pos_q;
          state_d = S_URD;
        end else begin
          i_d     = qnext;
          state_d = S_QRD;
        end
      end
      S_URD: begin
        ctl.rd  = 1'b1;
        state_d = S_UWR;
      end
      S_UWR: begin
        ctl.wr = 1'b1;
        if (unext > (IW + 1)'(VALUE_DOMAIN)) begin
          state_d = S_OUT;
        end else begin
          i_d     = unext[IW-1:0];
          state_d = S_URD;
        end
      end
      S_OUT: begin
        if (out_ld) begin
          i_d     = '0;
          state_d = last_q ? S_CLEAR : S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
        i_d     = '0;
      end
    endcase
  end

  // Chain of level cells; level one always counts one.
  assign ends[0] = kdsc_pkg::CNT_W'(1);

  for (genvar j = 0; j < NC; j++) begin : g_cell
    kdsc_cell #(
      .VALUE_DOMAIN(VALUE_DOMAIN)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .addr_i (addr),
      .prev_i (ends[j]),
      .ends_o (ends[j+1])
    );
  end

  // Running total.
  assign total_d = kdsc_pkg::add_mod(total_q, ends[kidx]);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      i_q     <= '0;
      pos_q   <= '0;
      last_q  <= 1'b0;
      k_q     <= kdsc_pkg::LEN_RESET;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      pos_q   <= pos_d;
      last_q  <= last_d;
      if (subsequence_length_we_i) begin
        k_q <= subsequence_length_i;
      end
      if (out_ld) begin
        total_q <= last_q ? '0 : total_d;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      count_q <= total_d;
      final_q <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign count_o     = count_q;
  assign final_res_o = final_q;

endmodule

// ----- hw/rtl/kdsc_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdsc_cell
// One level of the chain: a Fenwick tree over the reversed value domain,
// a query accumulator, and the write-back of the lower neighbor's count.
// ----------------------------------------------------------------------------
module kdsc_cell #(
  parameter int unsigned VALUE_DOMAIN = kdsc_pkg::DEF_VALUE_DOMAIN
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  kdsc_pkg::ctl_t               ctl_i,
  input  logic [$clog2(VALUE_DOMAIN)-1:0] addr_i,
  input  logic [kdsc_pkg::CNT_W-1:0]   prev_i,
  output logic [kdsc_pkg::CNT_W-1:0]   ends_o
);

  logic [kdsc_pkg::CNT_W-1:0] mem [VALUE_DOMAIN];
  logic [kdsc_pkg::CNT_W-1:0] rdata_q;
  logic [kdsc_pkg::CNT_W-1:0] acc_q, acc_d;
  logic [kdsc_pkg::CNT_W-1:0] wdata;

  // Node update: stored partial sum plus the count from the level below.
  assign wdata = ctl_i.wipe ? '0 : kdsc_pkg::add_mod(rdata_q, prev_i);

  // Tree memory, one access per cycle, registered read.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr || ctl_i.wipe) begin
      mem[addr_i] <= wdata;
    end
    if (ctl_i.rd) begin
      rdata_q <= mem[addr_i];
    end
  end

  // Query accumulator: sum over strictly greater values.
  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clr) begin
      acc_d = '0;
    end else if (ctl_i.acc) begin
      acc_d = kdsc_pkg::add_mod(acc_q, rdata_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign ends_o = acc_q;

endmodule

// ----- hw/rtl/kdsc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdsc_checker
// Port-level checks of the subsequence counter, bound to the top level.
// ----------------------------------------------------------------------------
`include "k_decreasing_subsequence_counter_top_macros.svh"

module kdsc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [kdsc_pkg::CNT_W-1:0] count_o,
  input logic                       final_res_o
);

  // No result word is shown in the cycle after reset was held.
  `KDSC_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !out_valid_o, "result valid after reset")

  // A stalled result word holds.
  `KDSC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(count_o) && $stable(final_res_o), "stalled result changed")

  // The count is always a residue.
  `KDSC_ASSERT(a_count_mod, out_valid_o |-> (count_o < kdsc_pkg::COUNT_MOD), "count not reduced")

  // After taking a word the block is busy for at least the next cycle.
  `KDSC_ASSERT(a_busy, in_valid_i && !in_stall_o |=> in_stall_o, "input taken twice in a row")

endmodule

bind k_decreasing_subsequence_counter_top kdsc_checker u_kdsc_checker (.*);

// ----- bench/k_decreasing_subsequence_counter_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_decreasing_subsequence_counter_top_tb
// Drives sequences of values into the subsequence counter under random
// input gaps and output stalls, and checks every result word against a
// behavioral count of decreasing subsequences kept by a scoreboard.
// ----------------------------------------------------------------------------

// Scoreboard: keeps per-level leaf counts and the running total, and queues
// the expected result word of every accepted input word.
class subseq_scoreboard;
  localparam int unsigned DOMAIN = 1024;
  localparam int unsigned LEVELS = 8;
  localparam logic [29:0] MODULUS = 30'd1000000000;

  logic [29:0] leaf_count[LEVELS+1][DOMAIN];
  logic [29:0] total;
  logic [3:0]  length_k;
  logic [29:0] count_q[$];
  logic        final_q[$];
  int          errors;

  function new();
    errors = 0;
    length_k = 4'd2;
    clear_sequence();
  endfunction

  function void clear_sequence();
    for (int l = 0; l <= LEVELS; l++) begin
      for (int v = 0; v < DOMAIN; v++) begin
        leaf_count[l][v] = '0;
      end
    end
    total = '0;
  endfunction

  function logic [29:0] mod_add(logic [29:0] a, logic [29:0] b);
    logic [30:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MODULUS}) begin
      s = s - {1'b0, MODULUS};
    end
    return s[29:0];
  endfunction

  // Computes the result of one accepted word and queues it.
  function void note_word(logic [10:0] value, logic last);
    logic [29:0] ends[LEVELS+1];
    int idx;
    int k;
    idx = (value < 1) ? 0 : (value > DOMAIN) ? DOMAIN - 1 : value - 1;
    k = (length_k < 1) ? 1 : (length_k > LEVELS) ? LEVELS : length_k;
    ends[1] = 30'd1;
    for (int l = 2; l <= LEVELS; l++) begin
      ends[l] = '0;
      for (int v = idx + 1; v < DOMAIN; v++) begin
        ends[l] = mod_add(ends[l], leaf_count[l][v]);
      end
    end
    for (int l = 2; l <= LEVELS; l++) begin
      leaf_count[l][idx] = mod_add(leaf_count[l][idx], ends[l-1]);
    end
    total = mod_add(total, ends[k]);
    count_q.push_back(total);
    final_q.push_back(last);
    if (last) begin
      clear_sequence();
    end
  endfunction

  task report(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  // Compares one accepted result word with the oldest expectation.
  task check_word(logic [29:0] count, logic final_res);
    logic [29:0] exp_count;
    logic        exp_final;
    if (count_q.size() == 0) begin
      report($sformatf("unexpected result count=%0d", count));
      return;
    end
    exp_count = count_q.pop_front();
    exp_final = final_q.pop_front();
    if (count !== exp_count) begin
      report($sformatf("count %0d, expected %0d", count, exp_count));
    end
    if (final_res !== exp_final) begin
      report($sformatf("final_res %0b, expected %0b", final_res, exp_final));
    end
  endtask
endclass

module k_decreasing_subsequence_counter_top_tb;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       subsequence_length_we_i = 1'b0;
  logic [kdsc_pkg::LEN_W-1:0] subsequence_length_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [kdsc_pkg::VAL_W-1:0] value_i = '0;
  logic                       last_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [kdsc_pkg::CNT_W-1:0] count_o;
  logic                       final_res_o;

  subseq_scoreboard board = new();
  bit               stall_enable = 1'b1;

  k_decreasing_subsequence_counter_top dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .subsequence_length_we_i(subsequence_length_we_i),
    .subsequence_length_i(subsequence_length_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .value_i(value_i),
    .last_i(last_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .count_o(count_o),
    .final_res_o(final_res_o)
  );

  always #10 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one.
  function automatic int gap_length();
    if ($urandom_range(0, 19) == 0) begin
      return $urandom_range(10, 60);
    end
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  // Sends one word and waits until it is taken. Valid drops between words;
  // the block is busy then anyway.
  task automatic send_word(logic [kdsc_pkg::VAL_W-1:0] value, logic last, bit idle_gaps);
    int gap;
    gap = idle_gaps ? gap_length() : 0;
    repeat (gap + 1) @(negedge clk_i);
    in_valid_i <= 1'b1;
    value_i    <= value;
    last_i     <= last;
    do @(posedge clk_i); while (in_stall_o);
    board.note_word(value, last);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Waits for all results to drain, then writes the length register.
  task automatic write_length(logic [kdsc_pkg::LEN_W-1:0] k);
    while (board.count_q.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    subsequence_length_we_i <= 1'b1;
    subsequence_length_i    <= k;
    @(negedge clk_i);
    subsequence_length_we_i <= 1'b0;
    board.length_k = k;
  endtask

  // Sends one random sequence; values usually come from a narrow band so
  // that decreasing runs and repeats are common.
  task automatic send_sequence(int len);
    int lo;
    int hi;
    logic [kdsc_pkg::VAL_W-1:0] v;
    lo = $urandom_range(1, 1024);
    hi = ($urandom_range(0, 3) == 0) ? 1024 : lo + $urandom_range(0, 40);
    if (hi > 1024) hi = 1024;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        v = kdsc_pkg::VAL_W'($urandom_range(0, 2047));
      end else begin
        v = kdsc_pkg::VAL_W'($urandom_range(lo, hi));
      end
      send_word(v, i == len - 1, 1'b1);
    end
  endtask

  // Result side: random stalls, check on every accepted word.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_word(count_o, final_res_o);
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= stall_enable ? (gap_length() != 0) : 1'b0;
  end

  // Stimulus.
  initial begin
    int sent;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    // Directed: domain extremes, out of range values, repeats, k = 0, 1, 3, 8 and 15.
    send_word(11'd1024, 1'b0, 1'b0);
    send_word(11'd1024, 1'b0, 1'b0);
    send_word(11'd2047, 1'b0, 1'b0);
    send_word(11'd512, 1'b0, 1'b0);
    send_word(11'd1, 1'b0, 1'b0);
    send_word(11'd0, 1'b0, 1'b0);
    send_word(11'd1025, 1'b1, 1'b0);
    write_length(4'd1);
    for (int i = 0; i < 4; i++) send_word(11'(1000 - i), i == 3, 1'b0);
    write_length(4'd8);
    for (int i = 0; i < 9; i++) send_word(11'(1024 - 100 * i), 1'b0, 1'b0);
    write_length(4'd3);
    send_word(11'd5, 1'b1, 1'b0);
    write_length(4'd0);
    send_word(11'd9, 1'b0, 1'b0);
    send_word(11'd3, 1'b1, 1'b0);
    write_length(4'd15);
    send_word(11'd7, 1'b1, 1'b0);
    // Random sequences, the length changed between some of them.
    sent = 0;
    while (sent < 1800) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                         : $urandom_range(1, 30);
      if ($urandom_range(0, 3) == 0) begin
        write_length(kdsc_pkg::LEN_W'($urandom_range(0, 15)));
      end
      if ($urandom_range(0, 9) == 0) begin
        stall_enable = ~stall_enable;
      end
      send_sequence(len);
      sent += len;
    end
    while (board.count_q.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (board.errors == 0 && board.count_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule
